// ----- hdl/lru_tile_cache_lookup_macros.svh -----
// Assertion macros shared by the tile cache lookup RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef LRU_TILE_CACHE_LOOKUP_MACROS_SVH
`define LRU_TILE_CACHE_LOOKUP_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset
`define LTCL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ltcl assertion failed");
// Condition must never be true outside reset
`define LTCL_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ltcl forbidden condition seen");
`else
`define LTCL_ASSERT(lbl, clk, rst, prop)
`define LTCL_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ----- hdl/ltcl_pkg.sv -----
// Shared types and constants for the tile cache lookup.
// No dependencies; used by ltcl_store, ltcl_cmp and the top level.
`default_nettype none

package ltcl_pkg;

   localparam int KEY_W   = 16;
   localparam int STAMP_W = 32;
   localparam int SLOT_W  = 5;

   // Lookup sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   // One directory entry: tile key plus last-access stamp
   typedef struct packed {
      logic [KEY_W-1:0]   key_x;
      logic [KEY_W-1:0]   key_z;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // Compare unit result
   typedef struct packed {
      logic match;
      logic older;
   } cmp_result_type;

endpackage

`default_nettype wire

// ----- hdl/ltcl_store.sv -----
// Entry memory of the tile cache directory: one write port, one read port,
// registered read data. Depends on ltcl_pkg.
`default_nettype none

module ltcl_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic                clock,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output      ltcl_pkg::entry_type rd_data,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire ltcl_pkg::entry_type wr_data
);

   ltcl_pkg::entry_type mem [DEPTH];
   ltcl_pkg::entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/ltcl_cmp.sv -----
// Shared compare unit: key equality and unsigned stamp age test for the
// entry under scan. Depends on ltcl_pkg.
`default_nettype none

module ltcl_cmp (
   input  wire logic [ltcl_pkg::KEY_W-1:0]   key_x,
   input  wire logic [ltcl_pkg::KEY_W-1:0]   key_z,
   input  wire ltcl_pkg::entry_type          entry,
   input  wire logic [ltcl_pkg::STAMP_W-1:0] oldest,
   output      ltcl_pkg::cmp_result_type     result
);

   // Tag match on both halves of the key
   assign result.match = (entry.key_x == key_x) && (entry.key_z == key_z);
   // Strictly older stamp, unsigned compare
   assign result.older = entry.stamp < oldest;

endmodule

`default_nettype wire

// ----- hdl/lru_tile_cache_lookup.sv -----
// Tile cache lookup: fully associative directory of ENTRIES slots with
// timestamp LRU replacement. A request scans the filled slots in order, one
// memory read and one compare per cycle through a single compare unit, and
// stops early on a hit. Slots fill in order and are never freed, so a fill
// count stands in for per-slot valid bits and no clearing pass is needed.
// The scan rate is set by the single read port of the entry memory. One
// request is in flight at a time; a finished response may wait on rsp_ready
// while the next request is accepted and scanned.
// Depends on ltcl_pkg, ltcl_store, ltcl_cmp and the macro header.
`default_nettype none

`include "lru_tile_cache_lookup_macros.svh"

module lru_tile_cache_lookup #(
   parameter int ENTRIES = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic signed [15:0] req_tile_x,
   input  wire logic signed [15:0] req_tile_z,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic               rsp_hit,
   output      logic [4:0]         rsp_slot,
   output      logic               rsp_filled_empty,
   output      logic signed [15:0] rsp_evicted_x,
   output      logic signed [15:0] rsp_evicted_z
);

   localparam int IDXW = $clog2(ENTRIES);
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int KW   = ltcl_pkg::KEY_W;
   localparam int SW   = ltcl_pkg::STAMP_W;

   // Control state
   ltcl_pkg::state_type state_ff, state_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            cmp_valid_ff, cmp_valid_in;
   logic [IDXW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic [SW-1:0]   clock_ff, clock_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Request payload and scan results
   logic [KW-1:0]   key_x_ff, key_x_in;
   logic [KW-1:0]   key_z_ff, key_z_in;
   logic            hit_ff, hit_in;
   logic [IDXW-1:0] hit_idx_ff, hit_idx_in;
   logic [IDXW-1:0] vic_idx_ff, vic_idx_in;
   logic [SW-1:0]   vic_stamp_ff, vic_stamp_in;
   logic [KW-1:0]   vic_x_ff, vic_x_in;
   logic [KW-1:0]   vic_z_ff, vic_z_in;

   // Response registers
   logic            rsp_hit_ff, rsp_hit_in;
   logic [4:0]      rsp_slot_ff, rsp_slot_in;
   logic            rsp_fe_ff, rsp_fe_in;
   logic [KW-1:0]   rsp_ev_x_ff, rsp_ev_x_in;
   logic [KW-1:0]   rsp_ev_z_ff, rsp_ev_z_in;

   // Memory and compare unit hookup
   logic                          rd_en;
   logic                          wr_en;
   logic [IDXW-1:0]               wr_addr;
   ltcl_pkg::entry_type           wr_data;
   ltcl_pkg::entry_type           rd_data;
   ltcl_pkg::cmp_result_type      cmp_res;
   logic                          issue;
   logic                          has_room;
   logic                          out_free;
   logic [IDXW-1:0]               tgt;

   ltcl_store #(
      .DEPTH (ENTRIES),
      .AW    (IDXW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[IDXW-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   ltcl_cmp u_cmp (
      .key_x  (key_x_ff),
      .key_z  (key_z_ff),
      .entry  (rd_data),
      .oldest (vic_stamp_ff),
      .result (cmp_res)
   );

   // Scan helpers
   assign issue    = idx_ff < fill_ff;
   assign has_room = fill_ff < CW'(ENTRIES);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign tgt      = hit_ff   ? hit_idx_ff :
                     has_room ? fill_ff[IDXW-1:0] : vic_idx_ff;

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      fill_in      = fill_ff;
      clock_in     = clock_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      key_x_in     = key_x_ff;
      key_z_in     = key_z_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      vic_idx_in   = vic_idx_ff;
      vic_stamp_in = vic_stamp_ff;
      vic_x_in     = vic_x_ff;
      vic_z_in     = vic_z_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_fe_in    = rsp_fe_ff;
      rsp_ev_x_in  = rsp_ev_x_ff;
      rsp_ev_z_in  = rsp_ev_z_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = tgt;
      wr_data      = '{key_x: key_x_ff, key_z: key_z_ff, stamp: clock_ff};

      unique case (state_ff)
         ltcl_pkg::ST_IDLE: begin
            if (req_valid) begin
               key_x_in     = req_tile_x;
               key_z_in     = req_tile_z;
               idx_in       = '0;
               cmp_valid_in = 1'b0;
               hit_in       = 1'b0;
               state_in     = ltcl_pkg::ST_SCAN;
            end
         end
         ltcl_pkg::ST_SCAN: begin
            // read the next filled slot, compare the one read last cycle
            cmp_valid_in = issue;
            cmp_idx_in   = idx_ff[IDXW-1:0];
            if (issue) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
            if (cmp_valid_ff && !cmp_res.match &&
                (cmp_idx_ff == '0 || cmp_res.older)) begin
               vic_idx_in   = cmp_idx_ff;
               vic_stamp_in = rd_data.stamp;
               vic_x_in     = rd_data.key_x;
               vic_z_in     = rd_data.key_z;
            end
            if (cmp_valid_ff && cmp_res.match) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
               state_in   = ltcl_pkg::ST_WRITE;
            end else if (!issue) begin
               state_in = ltcl_pkg::ST_WRITE;
            end
         end
         ltcl_pkg::ST_WRITE: begin
            // update the touched slot and post the response
            if (out_free) begin
               wr_en        = 1'b1;
               clock_in     = clock_ff + SW'(1);
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_slot_in  = 5'(tgt);
               rsp_fe_in    = !hit_ff && has_room;
               if (!hit_ff && has_room) begin
                  fill_in = fill_ff + CW'(1);
               end
               if (!hit_ff && !has_room) begin
                  rsp_ev_x_in = vic_x_ff;
                  rsp_ev_z_in = vic_z_ff;
               end else begin
                  rsp_ev_x_in = '0;
                  rsp_ev_z_in = '0;
               end
               state_in = ltcl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ltcl_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ltcl_pkg::ST_IDLE;
         idx_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cmp_valid_ff <= cmp_valid_in;
         fill_ff      <= fill_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff   <= cmp_idx_in;
      key_x_ff     <= key_x_in;
      key_z_ff     <= key_z_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      vic_idx_ff   <= vic_idx_in;
      vic_stamp_ff <= vic_stamp_in;
      vic_x_ff     <= vic_x_in;
      vic_z_ff     <= vic_z_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_fe_ff    <= rsp_fe_in;
      rsp_ev_x_ff  <= rsp_ev_x_in;
      rsp_ev_z_ff  <= rsp_ev_z_in;
   end

   // Ports
   assign req_ready        = (state_ff == ltcl_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_filled_empty = rsp_fe_ff;
   assign rsp_evicted_x    = rsp_ev_x_ff;
   assign rsp_evicted_z    = rsp_ev_z_ff;

   // Checks
   `LTCL_NEVER(a_fill_bound, clock, reset, fill_ff > CW'(ENTRIES))
   `LTCL_NEVER(a_hit_and_fill, clock, reset, rsp_valid_ff && rsp_hit_ff && rsp_fe_ff)
   `LTCL_ASSERT(a_clock_step, clock, reset, wr_en |=> clock_ff == $past(clock_ff) + SW'(1))
   `LTCL_ASSERT(a_fill_step, clock, reset,
      (wr_en && !hit_ff && has_room) |=> fill_ff == $past(fill_ff) + CW'(1))
   `LTCL_NEVER(a_scan_past_fill, clock, reset, rd_en && !(idx_ff < fill_ff))

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking bench for the tile cache lookup: a directed table, then a random key stream.
// Uses ltcl_pkg widths. Expected: typed rows, else an in-bench LRU directory model.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_W   = ltcl_pkg::KEY_W;
   localparam int SLOT_W  = ltcl_pkg::SLOT_W;
   localparam int STAMP_W = ltcl_pkg::STAMP_W;

   localparam int SLOTS          = 32;
   localparam int RANDOM_ITEMS   = 500;
   localparam int POOL_SIZE      = 40;
   localparam int RECENT_DEPTH   = 8;
   localparam int HOLDOFF_CYCLES = 600;
   localparam int HOLDOFF_AFTER  = 120;
   localparam int DRAIN_CYCLES   = 40;
   localparam int STALL_LIMIT    = 4000;
   localparam int EXP_DEPTH      = 16;

   // One response of the block
   typedef struct packed {
      logic                    hit;
      logic [SLOT_W-1:0]       slot;
      logic                    filled;
      logic signed [KEY_W-1:0] ev_x;
      logic signed [KEY_W-1:0] ev_z;
   } tile_rsp_type;

   // One directed request; want is used only where typed is set
   typedef struct packed {
      logic signed [KEY_W-1:0] x;
      logic signed [KEY_W-1:0] z;
      logic                    typed;
      tile_rsp_type            want;
   } tile_row_type;

   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // Directed table: extremes, partial key matches, hits and in-order fills
   localparam tile_row_type DIRECTED_ROWS [21] = '{
      '{0,      0,      1'b1, '{1'b0, 5'd0, 1'b1, 16'sd0, 16'sd0}},
      '{-32768, -32768, 1'b1, '{1'b0, 5'd1, 1'b1, 16'sd0, 16'sd0}},
      '{32767,  32767,  1'b1, '{1'b0, 5'd2, 1'b1, 16'sd0, 16'sd0}},
      '{-32768, 32767,  1'b1, '{1'b0, 5'd3, 1'b1, 16'sd0, 16'sd0}},
      '{32767,  -32768, 1'b1, '{1'b0, 5'd4, 1'b1, 16'sd0, 16'sd0}},
      '{0,      0,      1'b1, '{1'b1, 5'd0, 1'b0, 16'sd0, 16'sd0}},
      '{32767,  32767,  1'b1, '{1'b1, 5'd2, 1'b0, 16'sd0, 16'sd0}},
      '{-1,     -1,     1'b1, '{1'b0, 5'd5, 1'b1, 16'sd0, 16'sd0}},
      '{0,      1,      1'b1, '{1'b0, 5'd6, 1'b1, 16'sd0, 16'sd0}},
      '{1,      0,      1'b1, '{1'b0, 5'd7, 1'b1, 16'sd0, 16'sd0}},
      '{-1,     -1,     1'b1, '{1'b1, 5'd5, 1'b0, 16'sd0, 16'sd0}},
      '{21845,  -21846, 1'b1, '{1'b0, 5'd8, 1'b1, 16'sd0, 16'sd0}},
      '{-21846, 21845,  1'b1, '{1'b0, 5'd9, 1'b1, 16'sd0, 16'sd0}},
      '{-32768, -32768, 1'b1, '{1'b1, 5'd1, 1'b0, 16'sd0, 16'sd0}},
      '{0,      0,      1'b1, '{1'b1, 5'd0, 1'b0, 16'sd0, 16'sd0}},
      '{-21846, 21845,  1'b0, '0},
      '{256,    -256,   1'b0, '0},
      '{-256,   256,    1'b0, '0},
      '{0,      1,      1'b0, '0},
      '{1,      1,      1'b0, '0},
      '{-2,     -32768, 1'b0, '0}
   };

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_ready;
   logic signed [KEY_W-1:0] req_tile_x       = '0;
   logic signed [KEY_W-1:0] req_tile_z       = '0;
   logic                    rsp_valid;
   logic                    rsp_ready        = 1'b0;
   logic                    rsp_hit;
   logic [SLOT_W-1:0]       rsp_slot;
   logic                    rsp_filled_empty;
   logic signed [KEY_W-1:0] rsp_evicted_x;
   logic signed [KEY_W-1:0] rsp_evicted_z;

   // Sideband that travels with the request being offered
   logic         offer_typed = 1'b0;
   tile_rsp_type offer_want  = '0;

   // Directory model
   logic               dir_used  [SLOTS];
   logic [KEY_W-1:0]   dir_key_x [SLOTS];
   logic [KEY_W-1:0]   dir_key_z [SLOTS];
   logic [STAMP_W-1:0] dir_stamp [SLOTS];
   logic [STAMP_W-1:0] access_tick;

   // Expected responses in request order
   tile_rsp_type exp_fifo [EXP_DEPTH];
   int exp_wr = 0;
   int exp_rd = 0;

   // Key sources for the random stream
   logic [KEY_W-1:0] pool_x   [POOL_SIZE];
   logic [KEY_W-1:0] pool_z   [POOL_SIZE];
   logic [KEY_W-1:0] recent_x [RECENT_DEPTH];
   logic [KEY_W-1:0] recent_z [RECENT_DEPTH];
   int recent_wr  = 0;
   int sweep_left = 0;
   int sweep_pos  = 0;
   int burst_left = 0;

   int reqs_seen     = 0;
   int hit_count     = 0;
   int fill_count    = 0;
   int evict_count   = 0;
   int mismatches    = 0;
   bit holdoff_done  = 1'b0;

   lru_tile_cache_lookup #(
      .ENTRIES(SLOTS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_tile_x       (req_tile_x),
      .req_tile_z       (req_tile_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_slot         (rsp_slot),
      .rsp_filled_empty (rsp_filled_empty),
      .rsp_evicted_x    (rsp_evicted_x),
      .rsp_evicted_z    (rsp_evicted_z)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Scan the directory as the block does and update it for one request
   function automatic tile_rsp_type predict_lookup(logic [KEY_W-1:0] kx, logic [KEY_W-1:0] kz);
      tile_rsp_type       r;
      int                 i;
      int                 victim;
      bit                 found_empty;
      bit                 have_old;
      logic [STAMP_W-1:0] oldest;
      r           = '0;
      victim      = 0;
      found_empty = 1'b0;
      have_old    = 1'b0;
      oldest      = '0;
      for (i = 0; i < SLOTS; i++) begin
         if (!dir_used[i]) begin
            victim      = i;
            found_empty = 1'b1;
            break;
         end
         if (dir_key_x[i] == kx && dir_key_z[i] == kz) begin
            dir_stamp[i] = access_tick;
            access_tick  = access_tick + 1;
            r.hit        = 1'b1;
            r.slot       = SLOT_W'(i);
            return r;
         end
         // strictly older only, so ties keep the lower slot
         if (!have_old || dir_stamp[i] < oldest) begin
            victim   = i;
            oldest   = dir_stamp[i];
            have_old = 1'b1;
         end
      end
      if (!found_empty) begin
         r.ev_x = dir_key_x[victim];
         r.ev_z = dir_key_z[victim];
      end
      r.slot            = SLOT_W'(victim);
      r.filled          = found_empty;
      dir_used[victim]  = 1'b1;
      dir_key_x[victim] = kx;
      dir_key_z[victim] = kz;
      dir_stamp[victim] = access_tick;
      access_tick       = access_tick + 1;
      return r;
   endfunction

   // Mostly a working set a bit larger than the directory, plus recent repeats,
   // one-bit neighbors, fresh keys and in-order sweeps that defeat LRU
   task automatic pick_tile(output logic [KEY_W-1:0] x, output logic [KEY_W-1:0] z);
      int roll;
      int p;
      int b;
      roll = $urandom_range(0, 99);
      if (sweep_left == 0 && roll < 3) begin
         sweep_left = $urandom_range(SLOTS + 1, POOL_SIZE);
         sweep_pos  = $urandom_range(0, POOL_SIZE - 1);
      end
      if (sweep_left > 0) begin
         x          = pool_x[sweep_pos];
         z          = pool_z[sweep_pos];
         sweep_pos  = (sweep_pos + 1) % POOL_SIZE;
         sweep_left--;
      end else if (roll < 55) begin
         p = $urandom_range(0, POOL_SIZE - 1);
         x = pool_x[p];
         z = pool_z[p];
      end else if (roll < 72) begin
         p = $urandom_range(0, RECENT_DEPTH - 1);
         x = recent_x[p];
         z = recent_z[p];
      end else if (roll < 86) begin
         p = $urandom_range(0, POOL_SIZE - 1);
         x = pool_x[p];
         z = pool_z[p];
         b = $urandom_range(0, 2 * KEY_W - 1);
         if (b < KEY_W) x[b] = ~x[b];
         else z[b - KEY_W] = ~z[b - KEY_W];
      end else begin
         x = KEY_W'($urandom);
         z = KEY_W'($urandom);
         // now and then retire a pool key so the working set drifts
         if (roll > 95) begin
            p         = $urandom_range(0, POOL_SIZE - 1);
            pool_x[p] = x;
            pool_z[p] = z;
         end
      end
      recent_x[recent_wr] = x;
      recent_z[recent_wr] = z;
      recent_wr           = (recent_wr + 1) % RECENT_DEPTH;
   endtask

   // Offer one request at a falling edge, hold it until accepted, then maybe idle
   task automatic offer_tile(input logic signed [KEY_W-1:0] x, input logic signed [KEY_W-1:0] z,
                             input logic typed, input tile_rsp_type want);
      req_tile_x  <= x;
      req_tile_z  <= z;
      offer_typed <= typed;
      offer_want  <= want;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 15);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(negedge clock);
      end
   endtask

   // Predict on each accepted request, check each accepted response
   always @(posedge clock) begin : lookup_monitor
      tile_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = predict_lookup(req_tile_x, req_tile_z);
            if (offer_typed) want = offer_want;
            exp_fifo[exp_wr % EXP_DEPTH] = want;
            exp_wr++;
            reqs_seen++;
         end
         if (rsp_valid && rsp_ready) begin
            if (exp_wr == exp_rd) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = exp_fifo[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  mismatches++;
               end
               if (rsp_slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                  mismatches++;
               end
               if (rsp_filled_empty !== want.filled) begin
                  $error("filled_empty: expected %0d, got %0d", want.filled, rsp_filled_empty);
                  mismatches++;
               end
               if (rsp_evicted_x !== want.ev_x) begin
                  $error("evicted_x: expected %0d, got %0d", want.ev_x, rsp_evicted_x);
                  mismatches++;
               end
               if (rsp_evicted_z !== want.ev_z) begin
                  $error("evicted_z: expected %0d, got %0d", want.ev_z, rsp_evicted_z);
                  mismatches++;
               end
               if (want.hit) hit_count++;
               else if (want.filled) fill_count++;
               else evict_count++;
            end
         end
      end
   end

   // Response side: changing stall patterns, and one long hold-off to back up the block
   initial begin : rsp_side
      stall_mode_type mode;
      int             mode_left;
      int             phase;
      mode      = STALL_NONE;
      mode_left = 0;
      phase     = 0;
      forever begin
         @(negedge clock);
         if (!holdoff_done && reqs_seen >= HOLDOFF_AFTER) begin
            holdoff_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            phase++;
            case (mode)
               STALL_NONE:     rsp_ready <= 1'b1;
               STALL_HALF:     rsp_ready <= 1'($urandom_range(0, 1));
               STALL_HEAVY:    rsp_ready <= ($urandom_range(0, 3) == 0);
               STALL_PERIODIC: rsp_ready <= (phase % 7 == 0);
               default:        rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   // Ends the run if neither channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
               STALL_LIMIT, exp_wr - exp_rd);
      $display("== FAIL ==");
      $finish;
   end

   // Request side: reset, directed table, random stream, drain and verdict
   initial begin : req_side
      logic [KEY_W-1:0] kx;
      logic [KEY_W-1:0] kz;
      int               n;
      for (n = 0; n < SLOTS; n++) begin
         dir_used[n]  = 1'b0;
         dir_key_x[n] = '0;
         dir_key_z[n] = '0;
         dir_stamp[n] = '0;
      end
      access_tick = '0;
      for (n = 0; n < POOL_SIZE; n++) begin
         pool_x[n] = KEY_W'($urandom);
         pool_z[n] = KEY_W'($urandom);
      end
      for (n = 0; n < RECENT_DEPTH; n++) begin
         recent_x[n] = pool_x[n];
         recent_z[n] = pool_z[n];
      end

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r]) begin
         offer_tile(DIRECTED_ROWS[r].x, DIRECTED_ROWS[r].z, DIRECTED_ROWS[r].typed,
                    DIRECTED_ROWS[r].want);
      end
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pick_tile(kx, kz);
         offer_tile(kx, kz, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (exp_wr != exp_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (exp_wr != exp_rd) begin
         $error("%0d expected responses never arrived", exp_wr - exp_rd);
         mismatches++;
      end

      $display("covered %0d lookups (%0d directed): %0d hits, %0d empty-slot fills, %0d evictions",
               reqs_seen, $size(DIRECTED_ROWS), hit_count, fill_count, evict_count);
      $display("response hold-off of %0d cycles applied: %0d, field mismatches: %0d",
               HOLDOFF_CYCLES, holdoff_done, mismatches);
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
